// File: rtl/core/nwc_pkg.sv
// ----------------------------------------------------------------------------
// nwc_pkg
// Shared types and constants of the NFA word counter.
// ----------------------------------------------------------------------------
package nwc_pkg;

  localparam int COUNT_W = 30;
  localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic REG_ACCEPT = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

endpackage

// File: rtl/core/nfa_word_count_mod_prime.sv
// ----------------------------------------------------------------------------
// nfa_word_count_mod_prime
// Counts accepted words of a given length of an NFA, modulo 1e9+7.
// ----------------------------------------------------------------------------
// Add transition: read-modify-write of the transition RAM; a bad transition
// or an unused command is dropped with no write. Clear: all 2^(STW+CW) rows,
// one row per cycle; the same pass runs after reset and no request is taken
// meanwhile. Compute: builds the successor table, then runs L = word_length
// steps over the S = 2^N_STATES subsets and sums the accepting ones; the emit
// state holds while an earlier count waits at the output. One request at a time.
module nfa_word_count_mod_prime #(
  parameter int N_STATES  = 8,
  parameter int N_SYMBOLS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      cmd,
  input  logic [3:0]      from_state,
  input  logic [3:0]      to_state,
  input  logic [4:0]      symbol,
  output logic            out_valid,
  input  logic            out_ready,
  output nwc_pkg::count_t word_count,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);
  import nwc_pkg::*;

  localparam int SW   = N_STATES;
  localparam int STW  = (N_STATES > 1) ? $clog2(N_STATES) : 1;
  localparam int CW   = (N_SYMBOLS > 1) ? $clog2(N_SYMBOLS) : 1;
  localparam int TMAW = STW + CW;
  localparam int SCAW = SW + CW;

  typedef enum logic [3:0] {
    S_TM_CLR, S_IDLE, S_ADD_WR, S_SUCC_RD, S_SUCC_WR, S_INIT_CUR, S_STEP_CHK,
    S_CLR_NXT, S_RD_CUR, S_GOT_CUR, S_RD_SUCC, S_RD_NEXT, S_ACC,
    S_SUM_RD, S_SUM_ACC, S_EMIT
  } state_t;

  state_t          state;
  logic [7:0]      accept_mask;
  logic [15:0]     word_length;
  logic [15:0]     step;
  logic [TMAW-1:0] tm_idx;
  logic [TMAW-1:0] tm_waddr;
  logic [SW-1:0]   tm_bit;
  logic [SW-1:0]   sub_idx;
  logic [CW-1:0]   sym_idx;
  logic [SW-1:0]   dest;
  count_t          cur_val;
  count_t          total;
  logic            cur_bank;

  // transition RAM
  logic            tm_we;
  logic [TMAW-1:0] tm_wa;
  logic [SW-1:0]   tm_wd;
  logic [TMAW-1:0] tm_ra;
  logic [SW-1:0]   tm_rdata;
  // successor RAM
  logic            sc_we;
  logic [SCAW-1:0] sc_ra;
  logic [SW-1:0]   sc_wd;
  logic [SW-1:0]   sc_rdata;
  // count banks
  logic            cur_we;
  logic            nxt_we;
  logic [SW-1:0]   cnt_wa;
  count_t          cnt_wd;
  logic [SW-1:0]   cur_ra;
  logic [SW-1:0]   nxt_ra;
  count_t          cur_rdata;
  count_t          nxt_rdata;
  logic            a_we;
  logic            b_we;
  logic [SW-1:0]   a_ra;
  logic [SW-1:0]   b_ra;
  count_t          a_rdata;
  count_t          b_rdata;

  count_t          add_a;
  count_t          add_b;
  count_t          add_sum;

  logic            tran_ok;
  logic [TMAW-1:0] tran_addr;
  logic [SW-1:0]   tran_bit;
  logic [SW-1:0]   acc_bits;
  logic [SW-1:0]   sub_low;
  logic            sym_last;
  logic            sub_last;
  logic            in_fire;

  function automatic logic [STW-1:0] low_bit(input logic [SW-1:0] s);
    logic [STW-1:0] r;
    r = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (s[i]) r = STW'(i);
    end
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign sym_last  = (sym_idx == CW'(N_SYMBOLS - 1));
  assign sub_last  = &sub_idx;
  assign sub_low   = sub_idx & (sub_idx - SW'(1));

  always_comb begin
    tran_ok = (from_state != 4'd0) && (32'(from_state) <= N_STATES) &&
              (to_state != 4'd0) && (32'(to_state) <= N_STATES) &&
              (32'(symbol) < N_SYMBOLS);
    tran_addr = {STW'(from_state - 4'd1), CW'(symbol)};
    tran_bit  = SW'(1) << (to_state - 4'd1);
    for (int i = 0; i < SW; i++) begin
      acc_bits[i] = (i < 8) ? accept_mask[i % 8] : 1'b0;
    end
  end

  always_comb begin
    tm_we  = 1'b0;
    tm_wa  = tm_waddr;
    tm_wd  = tm_rdata | tm_bit;
    tm_ra  = (state == S_IDLE) ? tran_addr : {low_bit(sub_idx), sym_idx};
    sc_we  = 1'b0;
    sc_ra  = (state == S_SUCC_RD) ? {sub_low, sym_idx} : {sub_idx, sym_idx};
    sc_wd  = (sub_idx == '0) ? '0 : (sc_rdata | tm_rdata);
    cur_we = 1'b0;
    nxt_we = 1'b0;
    cnt_wa = sub_idx;
    cnt_wd = '0;
    cur_ra = sub_idx;
    nxt_ra = sc_rdata;
    add_a  = nxt_rdata;
    add_b  = cur_val;
    case (state)
      S_TM_CLR: begin
        tm_we = 1'b1;
        tm_wa = tm_idx;
        tm_wd = '0;
      end
      S_ADD_WR:   tm_we = 1'b1;
      S_SUCC_WR:  sc_we = 1'b1;
      S_INIT_CUR: begin
        cur_we = 1'b1;
        cnt_wd = (sub_idx == SW'(1)) ? count_t'(1) : '0;
      end
      S_CLR_NXT:  nxt_we = 1'b1;
      S_ACC: begin
        nxt_we = 1'b1;
        cnt_wa = dest;
        cnt_wd = add_sum;
      end
      S_SUM_ACC: begin
        add_a = cur_rdata;
        add_b = total;
      end
      default: ;
    endcase
    a_we      = cur_bank ? nxt_we : cur_we;
    b_we      = cur_bank ? cur_we : nxt_we;
    a_ra      = cur_bank ? nxt_ra : cur_ra;
    b_ra      = cur_bank ? cur_ra : nxt_ra;
    cur_rdata = cur_bank ? b_rdata : a_rdata;
    nxt_rdata = cur_bank ? a_rdata : b_rdata;
  end

  nwc_ram #(.WIDTH(SW), .DEPTH(1 << TMAW)) u_tm_ram (
    .clk(clk), .we(tm_we), .waddr(tm_wa), .wdata(tm_wd),
    .raddr(tm_ra), .rdata(tm_rdata)
  );

  nwc_ram #(.WIDTH(SW), .DEPTH(1 << SCAW)) u_succ_ram (
    .clk(clk), .we(sc_we), .waddr({sub_idx, sym_idx}), .wdata(sc_wd),
    .raddr(sc_ra), .rdata(sc_rdata)
  );

  nwc_ram #(.WIDTH(COUNT_W), .DEPTH(1 << SW)) u_cnt_a (
    .clk(clk), .we(a_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(a_ra), .rdata(a_rdata)
  );

  nwc_ram #(.WIDTH(COUNT_W), .DEPTH(1 << SW)) u_cnt_b (
    .clk(clk), .we(b_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(b_ra), .rdata(b_rdata)
  );

  nwc_addmod u_addmod (.a(add_a), .b(add_b), .sum(add_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_TM_CLR;
      tm_idx      <= '0;
      out_valid   <= 1'b0;
      accept_mask <= '0;
      word_length <= '0;
      cur_bank    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ACCEPT) accept_mask <= cfg_data[7:0];
        else                         word_length <= cfg_data;
      end
      if (out_valid && out_ready && (state != S_EMIT)) out_valid <= 1'b0;
      case (state)
        S_TM_CLR: begin
          tm_idx <= tm_idx + TMAW'(1);
          if (&tm_idx) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            case (cmd)
              CMD_ADD: begin
                if (tran_ok) begin
                  tm_waddr <= tran_addr;
                  tm_bit   <= tran_bit;
                  state    <= S_ADD_WR;
                end
              end
              CMD_COMPUTE: begin
                sub_idx <= '0;
                sym_idx <= '0;
                state   <= S_SUCC_RD;
              end
              CMD_CLEAR: begin
                tm_idx <= '0;
                state  <= S_TM_CLR;
              end
              default: ;
            endcase
          end
        end
        S_ADD_WR:  state <= S_IDLE;
        S_SUCC_RD: state <= S_SUCC_WR;
        S_SUCC_WR: begin
          if (sym_last) begin
            sym_idx <= '0;
            sub_idx <= sub_idx + SW'(1);
            if (sub_last) begin
              cur_bank <= 1'b0;
              state    <= S_INIT_CUR;
            end else begin
              state    <= S_SUCC_RD;
            end
          end else begin
            sym_idx <= sym_idx + CW'(1);
            state   <= S_SUCC_RD;
          end
        end
        S_INIT_CUR: begin
          sub_idx <= sub_idx + SW'(1);
          if (sub_last) begin
            step  <= '0;
            state <= S_STEP_CHK;
          end
        end
        S_STEP_CHK: begin
          sub_idx <= '0;
          total   <= '0;
          state   <= (step == word_length) ? S_SUM_RD : S_CLR_NXT;
        end
        S_CLR_NXT: begin
          sub_idx <= sub_idx + SW'(1);
          if (sub_last) state <= S_RD_CUR;
        end
        S_RD_CUR: state <= S_GOT_CUR;
        S_GOT_CUR: begin
          cur_val <= cur_rdata;
          sym_idx <= '0;
          if (cur_rdata != '0) begin
            state <= S_RD_SUCC;
          end else begin
            // skip empty subsets
            sub_idx <= sub_idx + SW'(1);
            if (sub_last) begin
              cur_bank <= ~cur_bank;
              step     <= step + 16'd1;
              state    <= S_STEP_CHK;
            end else begin
              state    <= S_RD_CUR;
            end
          end
        end
        S_RD_SUCC: state <= S_RD_NEXT;
        S_RD_NEXT: begin
          dest  <= sc_rdata;
          state <= S_ACC;
        end
        S_ACC: begin
          if (sym_last) begin
            sym_idx <= '0;
            sub_idx <= sub_idx + SW'(1);
            if (sub_last) begin
              cur_bank <= ~cur_bank;
              step     <= step + 16'd1;
              state    <= S_STEP_CHK;
            end else begin
              state    <= S_RD_CUR;
            end
          end else begin
            sym_idx <= sym_idx + CW'(1);
            state   <= S_RD_SUCC;
          end
        end
        S_SUM_RD: state <= S_SUM_ACC;
        S_SUM_ACC: begin
          if ((sub_idx & acc_bits) != '0) total <= add_sum;
          sub_idx <= sub_idx + SW'(1);
          state   <= sub_last ? S_EMIT : S_SUM_RD;
        end
        S_EMIT: begin
          // hold until the previous result has been taken
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            word_count <= total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_count < PRIME))
    else $error("result not reduced modulo the prime");

  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (cmd == CMD_COMPUTE)) |=> !in_ready)
    else $error("ready while computing");

  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    !(a_we && b_we))
    else $error("both count banks written at once");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM_ACC) |=> (total < PRIME))
    else $error("running sum out of range");
endmodule

// File: rtl/core/nwc_ram.sv
// ----------------------------------------------------------------------------
// nwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/nwc_addmod.sv
// ----------------------------------------------------------------------------
// nwc_addmod
// Modular adder: sum of two residues, reduced once by the prime.
// ----------------------------------------------------------------------------
module nwc_addmod (
  input  nwc_pkg::count_t a,
  input  nwc_pkg::count_t b,
  output nwc_pkg::count_t sum
);
  import nwc_pkg::*;

  logic [COUNT_W:0] raw;
  logic [COUNT_W:0] red;

  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    red = raw - {1'b0, PRIME};
    sum = (raw >= {1'b0, PRIME}) ? red[COUNT_W-1:0] : raw[COUNT_W-1:0];
  end
endmodule

// File: verif/nfa_word_count_mod_prime_test.sv
// ----------------------------------------------------------------------------
// nfa_word_count_mod_prime_test
// Self-checking bench: loads transitions, computes accepted-word counts and
// checks each count against a subset-construction predictor in the bench.
// ----------------------------------------------------------------------------
module nfa_word_count_mod_prime_test;
  import nwc_pkg::*;

  localparam int NST = 8;
  localparam int NSYM = 32;
  localparam int NSUB = 1 << NST;
  localparam int SETTLE = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [3:0]  from_state;
  logic [3:0]  to_state;
  logic [4:0]  symbol;
  logic        out_valid;
  logic        out_ready;
  count_t      word_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  logic [7:0]  nfa_targets [NST][NSYM];
  logic [7:0]  accept_bits;
  logic [15:0] length_reg;
  count_t      expected_counts[$];
  int          mismatches;
  bit          idle_en;
  bit          stall_en;
  int          hold_left;

  nfa_word_count_mod_prime dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .from_state(from_state), .to_state(to_state), .symbol(symbol),
    .out_valid(out_valid), .out_ready(out_ready), .word_count(word_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Count words of length_reg by stepping over subsets of NFA states.
  function automatic count_t count_accepted_words();
    logic [7:0] succ [NSUB][NSYM];
    longint     cur [NSUB];
    longint     nxt [NSUB];
    longint     total;
    int         low;
    int         d;
    for (int c = 0; c < NSYM; c++) succ[0][c] = '0;
    for (int s = 1; s < NSUB; s++) begin
      low = 0;
      while (!s[low]) low++;
      for (int c = 0; c < NSYM; c++)
        succ[s][c] = succ[s & (s - 1)][c] | nfa_targets[low][c];
    end
    for (int s = 0; s < NSUB; s++) cur[s] = 0;
    cur[1] = 1;
    for (int st = 0; st < length_reg; st++) begin
      for (int s = 0; s < NSUB; s++) nxt[s] = 0;
      for (int s = 0; s < NSUB; s++) begin
        if (cur[s] != 0) begin
          for (int c = 0; c < NSYM; c++) begin
            d = succ[s][c];
            nxt[d] = (nxt[d] + cur[s]) % PRIME;
          end
        end
      end
      cur = nxt;
    end
    total = 0;
    for (int s = 0; s < NSUB; s++)
      if ((s & accept_bits) != 0) total = (total + cur[s]) % PRIME;
    return count_t'(total);
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected count %0d", word_count);
      end else begin
        if (word_count !== expected_counts[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word_count mismatch: expected %0d actual %0d",
                     expected_counts[0], word_count);
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  // Call at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input cmd_t c, input logic [3:0] f, input logic [3:0] t,
                              input logic [4:0] s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    from_state <= f;
    to_state <= t;
    symbol <= s;
    do @(posedge clk); while (!in_ready);
    case (c)
      CMD_ADD: begin
        if (f >= 1 && f <= NST && t >= 1 && t <= NST)
          nfa_targets[f - 1][s][t - 1] = 1'b1;
      end
      CMD_COMPUTE: expected_counts = {expected_counts, count_accepted_words()};
      CMD_CLEAR: begin
        foreach (nfa_targets[i, j]) nfa_targets[i][j] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    // let a trailing clear or add finish
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ACCEPT) accept_bits = value[7:0];
    else length_reg = value;
  endtask

  task automatic add_random_transition();
    logic [3:0] f;
    logic [3:0] t;
    f = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, NST));
    t = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, NST));
    send_request(CMD_ADD, f, t, 5'($urandom_range(0, NSYM - 1)));
  endtask

  task automatic test_zero_length();
    write_reg(REG_LENGTH, 16'd0);
    write_reg(REG_ACCEPT, 16'h0001);
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
    write_reg(REG_ACCEPT, 16'h00FE);
    send_request(CMD_COMPUTE, 4'd15, 4'd15, 5'd31);
  endtask

  task automatic test_directed_items();
    write_reg(REG_ACCEPT, 16'h00FF);
    write_reg(REG_LENGTH, 16'd1);
    send_request(CMD_COMPUTE, 4'd1, 4'd1, 5'd0);
    send_request(CMD_ADD, 4'd1, 4'd8, 5'd0);
    send_request(CMD_ADD, 4'd8, 4'd1, 5'd31);
    send_request(CMD_ADD, 4'd1, 4'd8, 5'd0);
    send_request(CMD_ADD, 4'd0, 4'd2, 5'd3);
    send_request(CMD_ADD, 4'd15, 4'd2, 5'd3);
    send_request(CMD_ADD, 4'd2, 4'd0, 5'd4);
    send_request(CMD_ADD, 4'd2, 4'd9, 5'd4);
    send_request(CMD_NOP, 4'd1, 4'd2, 5'd5);
    send_request(CMD_ADD, 4'd1, 4'd1, 5'd16);
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
    write_reg(REG_LENGTH, 16'd2);
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
    write_reg(REG_ACCEPT, 16'h0080);
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
    send_request(CMD_CLEAR, 4'd0, 4'd0, 5'd0);
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
  endtask

  // Full-scale length register; only loads and a clear run under it.
  task automatic test_long_length();
    write_reg(REG_LENGTH, 16'hFFFF);
    write_reg(REG_ACCEPT, 16'h0000);
    repeat (6) add_random_transition();
    send_request(CMD_CLEAR, 4'hF, 4'hF, 5'h1F);
    write_reg(REG_LENGTH, 16'd3);
    repeat (4) add_random_transition();
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
  endtask

  task automatic test_backpressure();
    write_reg(REG_LENGTH, 16'd1);
    hold_left = 60000;
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
    repeat (8) add_random_transition();
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 5'd0);
    // keep offering loads while both counts sit behind the stalled output
    repeat (4) add_random_transition();
  endtask

  task automatic run_random_sequences(input int n_seq);
    int n_adds;
    for (int i = 0; i < n_seq; i++) begin
      write_reg(REG_ACCEPT, 16'($urandom_range(0, 255)));
      write_reg(REG_LENGTH, 16'($urandom_range(0, 3)));
      send_request(CMD_CLEAR, 4'($urandom), 4'($urandom), 5'($urandom));
      n_adds = $urandom_range(5, 40);
      for (int k = 0; k < n_adds; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_request(CMD_NOP, 4'($urandom), 4'($urandom), 5'($urandom));
        else
          add_random_transition();
      end
      send_request(CMD_COMPUTE, 4'($urandom), 4'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_random();
    run_random_sequences(39);
  endtask

  task automatic test_no_idling();
    idle_en = 1'b0;
    stall_en = 1'b0;
    run_random_sequences(6);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_NOP;
    from_state = '0;
    to_state = '0;
    symbol = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACCEPT;
    cfg_data = '0;
    mismatches = 0;
    hold_left = 0;
    idle_en = 1'b1;
    stall_en = 1'b1;
    accept_bits = '0;
    length_reg = '0;
    foreach (nfa_targets[i, j]) nfa_targets[i][j] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_zero_length();
    test_directed_items();
    test_long_length();
    test_backpressure();
    test_random();
    test_no_idling();

    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
